>>> rtl/kkse_pkg.sv
// types and constants shared by the key and knob scan event unit
package kkse_pkg;

  localparam int KEY_BITS  = 12;
  localparam int KNOB_BITS = 4;
  localparam int KEY_IDX_W = 4;

  localparam logic [6:0] VOLUME_MAX  = 7'd64;
  localparam logic [6:0] VOLUME_STEP = 7'd8;
  localparam logic [2:0] OCTAVE_MAX  = 3'd6;
  localparam logic [1:0] WAVE_MAX    = 2'b11;

  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_PRESS   = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  typedef enum logic [1:0] {
    TURN_NONE,
    TURN_UP,
    TURN_DOWN
  } turn_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]  key_rows;
    logic [KNOB_BITS-1:0] knob_row_three;
    logic [KNOB_BITS-1:0] knob_row_four;
    logic                 playback_done;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [KEY_IDX_W-1:0] key_number;
    logic [2:0]           octave_now;
    logic [6:0]           volume_now;
    logic [1:0]           wave_now;
    logic [1:0]           screen_now;
    logic                 master_flag;
    logic                 recording_flag;
    logic                 playback_flag;
    logic                 start_timer;
    logic                 exit_playback;
    logic                 last;
  } out_item_t;

  function automatic turn_t knob_turn(input logic [1:0] before_v, input logic [1:0] now_v);
    turn_t t;
    t = TURN_NONE;
    if ((before_v == 2'd0 && now_v == 2'd1) || (before_v == 2'd3 && now_v == 2'd2)) begin
      t = TURN_UP;
    end else if ((before_v == 2'd0 && now_v == 2'd2) ||
                 (before_v == 2'd2 && now_v == 2'd3)) begin
      t = TURN_DOWN;
    end
    return t;
  endfunction

endpackage

>>> rtl/kkse_if.sv
// valid/ready channels for scan requests and result requests
interface kkse_in_if;
  logic               valid;
  logic               ready;
  kkse_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface kkse_out_if;
  logic                valid;
  logic                ready;
  kkse_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/key_and_knob_scan_event_unit_top.sv
// key and knob scan event unit: knob decode, settings menu and key event emitter
// the accepted scan is held in the scan registers, and its status result then passes through the output register
// throughput: one result per cycle unless the result channel stalls; a scan gives 1 + (changed keys) results, 1 to 13
// the next scan is accepted in the cycle the current scan's final result is loaded
// the output register decouples the emitter from a stalled result channel
// reset (synchronous, active low): all keys released, knobs zero, settings and flags clear
module key_and_knob_scan_event_unit_top #(
  parameter int KEY_ROWS    = 3,
  parameter int KEY_COLUMNS = 4
) (
  input logic             clk,
  input logic             rst_n,
  kkse_in_if.sink         in_scan,
  kkse_out_if.source      out_event
);
  import kkse_pkg::*;

  localparam int KEY_TOTAL = (KEY_ROWS * KEY_COLUMNS > KEY_BITS) ? KEY_BITS
                                                                  : KEY_ROWS * KEY_COLUMNS;
  localparam logic [KEY_BITS-1:0] KEY_MASK = {KEY_BITS{1'b1}} >> (KEY_BITS - KEY_TOTAL);

  typedef enum logic [1:0] {
    SCR_MAIN,
    SCR_SETTINGS,
    SCR_RECORD,
    SCR_PLAYBACK
  } screen_t;

  typedef struct packed {
    logic [2:0] octave;
    logic [6:0] volume;
    logic [1:0] wave;
    screen_t    screen;
    logic       master;
    logic       rec;
    logic       play;
    logic       start;
    logic       exitp;
  } scan_info_t;

  // persistent state
  logic [KEY_BITS-1:0]  prev_keys_r;
  logic [KNOB_BITS-1:0] prev_row3_r, prev_row4_r;
  logic [6:0]           volume_r, volume_nxt;
  logic [2:0]           octave_r, octave_nxt;
  logic [1:0]           wave_r, wave_nxt;
  screen_t              screen_r, screen_nxt;
  logic                 master_r, master_nxt;
  logic                 rec_r, rec_nxt;
  logic                 play_r, play_nxt;
  logic                 start_nxt, exitp_nxt;

  // scan held for emission
  logic                 scan_valid_r;
  logic                 stat_pend_r;
  logic [KEY_BITS-1:0]  mask_r, mask_nxt;
  logic [KEY_BITS-1:0]  kprev_r;
  scan_info_t           info_r;

  // output register
  logic                 out_valid_r;
  out_item_t            out_r, out_nxt;

  turn_t                k0, k1, k2, k3;
  in_item_t             req;
  logic                 in_acc;
  logic                 out_load;
  logic                 emit_last;
  logic [KEY_IDX_W-1:0] idx;
  logic [KEY_BITS-1:0]  mask_rest;

  assign req = in_scan.payload;

  assign k0 = knob_turn(prev_row4_r[3:2], req.knob_row_four[3:2]);
  assign k1 = knob_turn(prev_row4_r[1:0], req.knob_row_four[1:0]);
  assign k2 = knob_turn(prev_row3_r[3:2], req.knob_row_three[3:2]);
  assign k3 = knob_turn(prev_row3_r[1:0], req.knob_row_three[1:0]);

  always_comb begin
    volume_nxt = volume_r;
    octave_nxt = octave_r;
    wave_nxt   = wave_r;
    screen_nxt = screen_r;
    master_nxt = master_r;
    rec_nxt    = rec_r;
    play_nxt   = play_r & ~req.playback_done;
    start_nxt  = 1'b0;
    exitp_nxt  = 1'b0;
    case (screen_r)
      SCR_MAIN: begin
        if (k0 == TURN_UP) begin
          volume_nxt = (volume_r >= VOLUME_MAX - VOLUME_STEP) ? VOLUME_MAX
                                                              : volume_r + VOLUME_STEP;
        end else if (k0 == TURN_DOWN) begin
          volume_nxt = (volume_r < VOLUME_STEP) ? 7'd0 : volume_r - VOLUME_STEP;
        end
        if (k1 == TURN_UP) begin
          octave_nxt = (octave_r >= OCTAVE_MAX) ? OCTAVE_MAX : octave_r + 3'd1;
        end else if (k1 == TURN_DOWN) begin
          octave_nxt = (octave_r == 3'd0) ? 3'd0 : octave_r - 3'd1;
        end
        if (k2 == TURN_UP) begin
          wave_nxt = (wave_r == WAVE_MAX) ? WAVE_MAX : wave_r + 2'd1;
        end else if (k2 == TURN_DOWN) begin
          wave_nxt = (wave_r == 2'd0) ? 2'd0 : wave_r - 2'd1;
        end
        if (k3 == TURN_UP) begin
          screen_nxt = SCR_SETTINGS;
        end
      end
      SCR_SETTINGS: begin
        if (k0 == TURN_UP) begin
          master_nxt = 1'b1;
        end else if (k0 == TURN_DOWN) begin
          master_nxt = 1'b0;
        end
        if (k1 == TURN_UP) begin
          screen_nxt = SCR_RECORD;
          rec_nxt    = 1'b1;
          start_nxt  = 1'b1;
        end
        if (k2 == TURN_UP) begin
          screen_nxt = SCR_PLAYBACK;
          play_nxt   = 1'b1;
          start_nxt  = 1'b1;
        end
        if (k3 == TURN_DOWN) begin
          screen_nxt = SCR_MAIN;
        end
      end
      SCR_RECORD: begin
        if (k3 == TURN_DOWN) begin
          screen_nxt = SCR_MAIN;
          rec_nxt    = 1'b0;
        end
      end
      default: begin
        if (k3 == TURN_DOWN) begin
          screen_nxt = SCR_MAIN;
          exitp_nxt  = 1'b1;
        end
      end
    endcase
    mask_nxt = play_nxt ? '0 : ((req.key_rows ^ prev_keys_r) & KEY_MASK);
  end

  // lowest pending key
  always_comb begin
    idx = '0;
    for (int k = KEY_BITS - 1; k >= 0; k--) begin
      if (mask_r[k]) begin
        idx = KEY_IDX_W'(k);
      end
    end
  end

  assign mask_rest = mask_r & (mask_r - KEY_BITS'(1));
  assign emit_last = stat_pend_r ? (mask_r == '0) : (mask_rest == '0);
  assign out_load  = scan_valid_r && (!out_valid_r || out_event.ready);
  assign in_acc    = in_scan.valid && in_scan.ready;

  assign in_scan.ready     = !scan_valid_r || (out_load && emit_last);
  assign out_event.valid   = out_valid_r;
  assign out_event.payload = out_r;

  always_comb begin
    out_nxt.kind           = KIND_STATUS;
    out_nxt.key_number     = '0;
    if (!stat_pend_r) begin
      out_nxt.kind       = kprev_r[idx] ? KIND_PRESS : KIND_RELEASE;
      out_nxt.key_number = idx;
    end
    out_nxt.octave_now     = info_r.octave;
    out_nxt.volume_now     = info_r.volume;
    out_nxt.wave_now       = info_r.wave;
    out_nxt.screen_now     = info_r.screen;
    out_nxt.master_flag    = info_r.master;
    out_nxt.recording_flag = info_r.rec;
    out_nxt.playback_flag  = info_r.play;
    out_nxt.start_timer    = info_r.start;
    out_nxt.exit_playback  = info_r.exitp;
    out_nxt.last           = emit_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_keys_r  <= '1;
      prev_row3_r  <= '0;
      prev_row4_r  <= '0;
      volume_r     <= '0;
      octave_r     <= '0;
      wave_r       <= '0;
      screen_r     <= SCR_MAIN;
      master_r     <= 1'b0;
      rec_r        <= 1'b0;
      play_r       <= 1'b0;
      scan_valid_r <= 1'b0;
      stat_pend_r  <= 1'b0;
      mask_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        prev_keys_r  <= req.key_rows;
        prev_row3_r  <= req.knob_row_three;
        prev_row4_r  <= req.knob_row_four;
        volume_r     <= volume_nxt;
        octave_r     <= octave_nxt;
        wave_r       <= wave_nxt;
        screen_r     <= screen_nxt;
        master_r     <= master_nxt;
        rec_r        <= rec_nxt;
        play_r       <= play_nxt;
        scan_valid_r <= 1'b1;
        stat_pend_r  <= 1'b1;
        mask_r       <= mask_nxt;
      end else if (out_load) begin
        if (stat_pend_r) begin
          stat_pend_r <= 1'b0;
        end else begin
          mask_r <= mask_rest;
        end
        if (emit_last) begin
          scan_valid_r <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_event.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kprev_r       <= prev_keys_r;
      info_r.octave <= octave_nxt;
      info_r.volume <= volume_nxt;
      info_r.wave   <= wave_nxt;
      info_r.screen <= screen_nxt;
      info_r.master <= master_nxt;
      info_r.rec    <= rec_nxt;
      info_r.play   <= play_nxt;
      info_r.start  <= start_nxt;
      info_r.exitp  <= exitp_nxt;
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

endmodule

>>> bench/tb_key_and_knob_scan_event_unit_top.sv
// testbench for the key and knob scan event unit: directed scan table, then random scans
module tb_key_and_knob_scan_event_unit_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kkse_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;
  localparam int SETTLE_CYCLES = 20;
  localparam int KEY_COUNT = 12;

  localparam logic [1:0] SCREEN_MAIN     = 2'd0;
  localparam logic [1:0] SCREEN_SETTINGS = 2'd1;
  localparam logic [1:0] SCREEN_RECORD   = 2'd2;
  localparam logic [1:0] SCREEN_PLAYBACK = 2'd3;

  typedef enum int {DRIFT_RANDOM, DRIFT_UP, DRIFT_DOWN, DRIFT_ANY, DRIFT_HOLD} drift_t;

  typedef struct packed {
    logic [11:0] keys;
    logic [3:0]  row_three;
    logic [3:0]  row_four;
    logic        done;
    logic        typed;
    logic        typed_last;
  } scan_row_t;

  typedef struct packed {
    logic      typed;
    out_item_t status;
  } scan_note_t;

  localparam int DIRECTED_ROWS = 23;
  scan_row_t directed_rows [DIRECTED_ROWS] = '{
    '{12'hFFF, 4'b0000, 4'b0000, 1'b0, 1'b1, 1'b1},
    '{12'h000, 4'b0000, 4'b0000, 1'b0, 1'b1, 1'b0},
    '{12'hFFF, 4'b0000, 4'b0000, 1'b0, 1'b1, 1'b0},
    '{12'hFFE, 4'b1000, 4'b1000, 1'b0, 1'b1, 1'b0},
    '{12'hFFE, 4'b1100, 4'b1110, 1'b0, 1'b1, 1'b1},
    '{12'hFFE, 4'b1000, 4'b1000, 1'b0, 1'b0, 1'b0},
    '{12'hF0F, 4'b0000, 4'b0000, 1'b0, 1'b0, 1'b0},
    '{12'hF0F, 4'b0101, 4'b0101, 1'b0, 1'b0, 1'b0},
    '{12'hF0F, 4'b0000, 4'b0000, 1'b0, 1'b0, 1'b0},
    '{12'h70F, 4'b0000, 4'b0100, 1'b0, 1'b0, 1'b0},
    '{12'h7FF, 4'b0100, 4'b0001, 1'b0, 1'b0, 1'b0},
    '{12'h000, 4'b0110, 4'b0001, 1'b0, 1'b0, 1'b0},
    '{12'hFFF, 4'b0110, 4'b0001, 1'b1, 1'b0, 1'b0},
    '{12'hFFF, 4'b0011, 4'b0001, 1'b0, 1'b0, 1'b0},
    '{12'hAAA, 4'b0010, 4'b0001, 1'b0, 1'b0, 1'b0},
    '{12'h555, 4'b0010, 4'b0000, 1'b0, 1'b0, 1'b0},
    '{12'h555, 4'b0011, 4'b1001, 1'b0, 1'b0, 1'b0},
    '{12'h555, 4'b0010, 4'b1001, 1'b0, 1'b0, 1'b0},
    '{12'h554, 4'b0010, 4'b1011, 1'b0, 1'b0, 1'b0},
    '{12'h554, 4'b0010, 4'b1010, 1'b0, 1'b0, 1'b0},
    '{12'h000, 4'b0011, 4'b1010, 1'b0, 1'b0, 1'b0},
    '{12'hFFF, 4'b1111, 4'b1111, 1'b1, 1'b0, 1'b0},
    '{12'hFFF, 4'b0000, 4'b0000, 1'b0, 1'b0, 1'b0}
  };

  logic clk;
  logic rst_n;

  kkse_in_if  in_scan ();
  kkse_out_if out_event ();

  key_and_knob_scan_event_unit_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_scan   (in_scan),
    .out_event (out_event)
  );

  // scan predictor state
  logic [11:0] kept_keys;
  logic [3:0]  kept_row_three;
  logic [3:0]  kept_row_four;
  int          volume_level;
  int          octave_level;
  int          wave_level;
  logic [1:0]  screen_level;
  logic        is_master;
  logic        is_recording;
  logic        is_playing;

  out_item_t   results_due [$];
  scan_note_t  scan_notes [$];
  out_item_t   oldest_due;
  scan_note_t  accepted_note;
  int          mismatch_count = 0;
  int          cycle_count = 0;

  // stimulus side
  int          send_idle_pct = 28;
  int          recv_idle_pct = 46;
  int          hold_asks = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  logic [11:0] sent_keys;
  logic [3:0]  sent_row_three;
  logic [3:0]  sent_row_four;

  always #10 clk = ~clk;

  function automatic turn_t knob_step(input logic [1:0] was, input logic [1:0] now_v);
    case ({was, now_v})
      4'b0001, 4'b1110: return TURN_UP;
      4'b0010, 4'b1011: return TURN_DOWN;
      default:          return TURN_NONE;
    endcase
  endfunction

  function automatic int turn_delta(input turn_t t);
    return (t == TURN_UP) ? 1 : (t == TURN_DOWN) ? -1 : 0;
  endfunction

  function automatic int clamp_to(input int v, input int hi);
    return (v < 0) ? 0 : (v > hi) ? hi : v;
  endfunction

  function automatic void predict_scan(input in_item_t s, input scan_note_t note);
    turn_t       t0, t1, t2, t3;
    logic [11:0] changed;
    logic        start_pulse;
    logic        exit_pulse;
    out_item_t   r;
    int          pending;
    t0 = knob_step(kept_row_four[3:2], s.knob_row_four[3:2]);
    t1 = knob_step(kept_row_four[1:0], s.knob_row_four[1:0]);
    t2 = knob_step(kept_row_three[3:2], s.knob_row_three[3:2]);
    t3 = knob_step(kept_row_three[1:0], s.knob_row_three[1:0]);
    start_pulse = 1'b0;
    exit_pulse = 1'b0;
    if (s.playback_done) is_playing = 1'b0;
    case (screen_level)
      SCREEN_MAIN: begin
        volume_level = clamp_to(volume_level + int'(VOLUME_STEP) * turn_delta(t0),
                                int'(VOLUME_MAX));
        octave_level = clamp_to(octave_level + turn_delta(t1), int'(OCTAVE_MAX));
        wave_level = clamp_to(wave_level + turn_delta(t2), int'(WAVE_MAX));
        if (t3 == TURN_UP) screen_level = SCREEN_SETTINGS;
      end
      SCREEN_SETTINGS: begin
        if (t0 == TURN_UP) is_master = 1'b1;
        else if (t0 == TURN_DOWN) is_master = 1'b0;
        if (t1 == TURN_UP) begin
          screen_level = SCREEN_RECORD;
          is_recording = 1'b1;
          start_pulse = 1'b1;
        end
        if (t2 == TURN_UP) begin
          screen_level = SCREEN_PLAYBACK;
          is_playing = 1'b1;
          start_pulse = 1'b1;
        end
        if (t3 == TURN_DOWN) screen_level = SCREEN_MAIN;
      end
      SCREEN_RECORD: begin
        if (t3 == TURN_DOWN) begin
          screen_level = SCREEN_MAIN;
          is_recording = 1'b0;
        end
      end
      default: begin
        if (t3 == TURN_DOWN) begin
          screen_level = SCREEN_MAIN;
          exit_pulse = 1'b1;
        end
      end
    endcase

    changed = is_playing ? 12'h000 : (s.key_rows ^ kept_keys);
    pending = $countones(changed);
    r.kind = KIND_STATUS;
    r.key_number = '0;
    r.octave_now = 3'(octave_level);
    r.volume_now = 7'(volume_level);
    r.wave_now = 2'(wave_level);
    r.screen_now = screen_level;
    r.master_flag = is_master;
    r.recording_flag = is_recording;
    r.playback_flag = is_playing;
    r.start_timer = start_pulse;
    r.exit_playback = exit_pulse;
    r.last = (pending == 0);
    results_due.push_back(note.typed ? note.status : r);
    for (int k = 0; k < KEY_COUNT; k++) begin
      if (changed[k]) begin
        pending--;
        r.kind = kept_keys[k] ? KIND_PRESS : KIND_RELEASE;
        r.key_number = KEY_IDX_W'(k);
        r.last = (pending == 0);
        results_due.push_back(r);
      end
    end
    kept_keys = s.key_rows;
    kept_row_three = s.knob_row_three;
    kept_row_four = s.knob_row_four;
  endfunction

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, actual %0d", name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  task automatic compare_result(input out_item_t want, input out_item_t got);
    check_field("kind", want.kind, got.kind);
    check_field("key_number", want.key_number, got.key_number);
    check_field("octave_now", want.octave_now, got.octave_now);
    check_field("volume_now", want.volume_now, got.volume_now);
    check_field("wave_now", want.wave_now, got.wave_now);
    check_field("screen_now", want.screen_now, got.screen_now);
    check_field("master_flag", want.master_flag, got.master_flag);
    check_field("recording_flag", want.recording_flag, got.recording_flag);
    check_field("playback_flag", want.playback_flag, got.playback_flag);
    check_field("start_timer", want.start_timer, got.start_timer);
    check_field("exit_playback", want.exit_playback, got.exit_playback);
    check_field("last", want.last, got.last);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      kept_keys = 12'hFFF;
      kept_row_three = '0;
      kept_row_four = '0;
      volume_level = 0;
      octave_level = 0;
      wave_level = 0;
      screen_level = SCREEN_MAIN;
      is_master = 1'b0;
      is_recording = 1'b0;
      is_playing = 1'b0;
    end else begin
      if (out_event.valid && out_event.ready) begin
        if (results_due.size() == 0) begin
          $error("result request with nothing pending: kind %0d key %0d",
                 out_event.payload.kind, out_event.payload.key_number);
          mismatch_count++;
        end else begin
          oldest_due = results_due.pop_front();
          compare_result(oldest_due, out_event.payload);
        end
      end
      if (in_scan.valid && in_scan.ready) begin
        accepted_note = scan_notes.pop_front();
        predict_scan(in_scan.payload, accepted_note);
      end
    end
  end

  // result side ready, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_asks != hold_served) begin
      hold_served = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_event.ready <= 1'b0;
    end else begin
      out_event.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic offer_scan(input in_item_t s, input scan_note_t note);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_scan.valid <= 1'b0;
      @(negedge clk);
    end
    scan_notes.push_back(note);
    in_scan.valid <= 1'b1;
    in_scan.payload <= s;
    sent_keys = s.key_rows;
    sent_row_three = s.knob_row_three;
    sent_row_four = s.knob_row_four;
    @(posedge clk);
    while (!(in_scan.valid && in_scan.ready)) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pause_until_drained();
    in_scan.valid <= 1'b0;
    do @(negedge clk); while (results_due.size() != 0);
  endtask

  function automatic logic [1:0] pick_knob(input logic [1:0] p, input drift_t mode);
    case (mode)
      DRIFT_UP:   return (p == 2'd3) ? 2'd2 : (p == 2'd0) ? 2'd1 : 2'd0;
      DRIFT_DOWN: return (p == 2'd0) ? 2'd2 : (p == 2'd2) ? 2'd3 : 2'd0;
      DRIFT_ANY: begin
        case (p)
          2'd0:    return $urandom_range(0, 1) ? 2'd1 : 2'd2;
          2'd1:    return $urandom_range(0, 1) ? 2'd0 : 2'd3;
          2'd2:    return 2'd3;
          default: return 2'd2;
        endcase
      end
      DRIFT_HOLD: return p;
      default:    return 2'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [11:0] pick_keys(input logic [11:0] p);
    int          roll;
    logic [11:0] k;
    roll = $urandom_range(0, 99);
    k = p;
    if (roll < 5) k = 12'h000;
    else if (roll < 10) k = 12'hFFF;
    else if (roll < 25) k = 12'($urandom);
    else if (roll < 85) begin
      repeat ($urandom_range(1, 3)) k[$urandom_range(0, KEY_COUNT - 1)] ^= 1'b1;
    end
    return k;
  endfunction

  task automatic run_random(input int count, input drift_t bias);
    in_item_t   s;
    scan_note_t note;
    drift_t     mode;
    drift_t     menu_mode;
    int         roll;
    note = '0;
    repeat (count) begin
      mode = bias;
      if (bias == DRIFT_RANDOM) mode = drift_t'($urandom_range(DRIFT_UP, DRIFT_ANY));
      roll = $urandom_range(0, 99);
      menu_mode = (roll < 40) ? DRIFT_ANY : (roll < 50) ? DRIFT_RANDOM : DRIFT_HOLD;
      s.key_rows = pick_keys(sent_keys);
      s.knob_row_four[3:2] = pick_knob(sent_row_four[3:2],
                                       ($urandom_range(0, 99) < 70) ? mode : DRIFT_RANDOM);
      s.knob_row_four[1:0] = pick_knob(sent_row_four[1:0],
                                       ($urandom_range(0, 99) < 70) ? mode : DRIFT_RANDOM);
      s.knob_row_three[3:2] = pick_knob(sent_row_three[3:2],
                                        ($urandom_range(0, 99) < 70) ? mode : DRIFT_RANDOM);
      s.knob_row_three[1:0] = pick_knob(sent_row_three[1:0], menu_mode);
      s.playback_done = ($urandom_range(0, 99) < 10);
      offer_scan(s, note);
    end
  endtask

  initial begin
    in_item_t   s;
    scan_note_t note;
    clk = 1'b0;
    rst_n = 1'b0;
    in_scan.valid = 1'b0;
    in_scan.payload = '0;
    out_event.ready = 1'b0;
    sent_keys = 12'hFFF;
    sent_row_three = '0;
    sent_row_four = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      s.key_rows = directed_rows[i].keys;
      s.knob_row_three = directed_rows[i].row_three;
      s.knob_row_four = directed_rows[i].row_four;
      s.playback_done = directed_rows[i].done;
      note = '0;
      note.typed = directed_rows[i].typed;
      note.status.kind = KIND_STATUS;
      note.status.last = directed_rows[i].typed_last;
      offer_scan(s, note);
    end
    pause_until_drained();
    run_random(47, DRIFT_UP);
    pause_until_drained();

    send_idle_pct = 46;
    recv_idle_pct <= 28;
    run_random(47, DRIFT_DOWN);
    pause_until_drained();

    // receiver holds off while scans keep coming
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_asks <= hold_asks + 1;
    run_random(53, DRIFT_RANDOM);
    pause_until_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
